FILE: hw/rtl/bankers_safety_and_request_defines.svh
// Assertion macros for the banker's block.
`ifndef BANKERS_SAFETY_AND_REQUEST_DEFINES_SVH
`define BANKERS_SAFETY_AND_REQUEST_DEFINES_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSR_ASSERT(label, clk, rst_n, prop, msg)
`define BSR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Types and constants shared by the banker's safety and request block.
// ----------------------------------------------------------------------------
`default_nettype none
package bsr_pkg;
    localparam int MAX_PROCS  = 8;
    localparam int MAX_RES    = 4;
    localparam int COUNT_BITS = 8;
    localparam int WORK_BITS  = COUNT_BITS + 4;
    localparam int PW         = 3;
    localparam int RW         = 2;
    localparam int NCELLS     = MAX_PROCS * MAX_RES;
    localparam int CW         = 5;

    typedef enum logic [2:0] {
        OP_LOAD_ALLOC = 3'd0,
        OP_LOAD_MAX   = 3'd1,
        OP_LOAD_AVAIL = 3'd2,
        OP_SAFETY     = 3'd3,
        OP_REQUEST    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_LOAD_OK   = 3'd0,
        ST_LOAD_BAD  = 3'd1,
        ST_SAFE      = 3'd2,
        ST_NOT_SAFE  = 3'd3,
        ST_GRANTED   = 3'd4,
        ST_OVER      = 3'd5,
        ST_WAIT      = 3'd6,
        ST_UNSAFE    = 3'd7
    } t_status;

    localparam logic [0:0] ADDR_PROCS = 1'b0;
    localparam logic [0:0] ADDR_RES   = 1'b1;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] proc_index;
        logic [1:0] res_index;
        logic [7:0] load_value;
        logic [7:0] req_units_0;
        logic [7:0] req_units_1;
        logic [7:0] req_units_2;
        logic [7:0] req_units_3;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] seq_process;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [3:0] np;
        logic [2:0] nr;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_RCHK, S_TRY, S_INIT, S_SCAN, S_ADD, S_PASS,
        S_EMIT, S_COMMIT, S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: hw/rtl/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front
// Accepts requests, drops unknown ops, queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bankers_safety_and_request_defines.svh"
module bsr_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  bsr_pkg::t_in_item    i_item,
    output logic                 o_full,
    output logic                 o_valid,
    output bsr_pkg::t_in_item    o_item,
    input  wire                  i_take
);
    bsr_pkg::t_in_item r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_acc, w_known;

    assign o_full  = (r_cnt == 2'd2);
    assign w_acc   = i_push && !o_full;
    assign w_known = (i_item.op <= 3'(bsr_pkg::OP_REQUEST));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_acc && w_known) begin
            n_wp = !r_wp;
        end
        if (i_take && o_valid) begin
            n_rp = !r_rp;
        end
        n_cnt = r_cnt + 2'(w_acc && w_known) - 2'(i_take && o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_known) begin
            r_q[r_wp] <= i_item;
        end
    end

    `BSR_ASSERT(a_cnt_max, i_clk, i_rst_n, (r_cnt <= 2'd2), "queue count overflow")
    `BSR_ASSERT(a_take_valid, i_clk, i_rst_n, (i_take |-> o_valid), "take while empty")
    `BSR_ASSERT(a_ptr, i_clk, i_rst_n, ((r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)), "pointer mismatch")
endmodule
`default_nettype wire

FILE: hw/rtl/bsr_engine.sv
// ----------------------------------------------------------------------------
// bsr_engine
// Carries out loads, safety scans and requests; a scan checks one process row per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bankers_safety_and_request_defines.svh"
module bsr_engine (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  bsr_pkg::t_cfg        i_cfg,
    input  wire                  i_valid,
    input  bsr_pkg::t_in_item    i_item,
    output logic                 o_take,
    input  wire                  i_pop,
    output logic                 o_empty,
    output bsr_pkg::t_out_item   o_res
);
    localparam int MP = bsr_pkg::MAX_PROCS;
    localparam int MR = bsr_pkg::MAX_RES;
    localparam int CB = bsr_pkg::COUNT_BITS;
    localparam int WB = bsr_pkg::WORK_BITS;

    logic [CB-1:0] r_alloc [MP][MR];
    logic [CB-1:0] r_need  [MP][MR];
    logic [CB-1:0] r_avail [MR];
    logic [CB-1:0] r_talloc [MR];
    logic [CB-1:0] r_tneed  [MR];
    logic [CB-1:0] r_tavail [MR];
    logic [WB-1:0] r_work [MR];
    logic [MP-1:0] r_fin;
    logic [2:0]    r_ord [MP];
    logic [3:0]    r_cnt;
    logic [2:0]    r_p;
    logic          r_found;
    logic          r_try;
    bsr_pkg::t_in_item r_it;
    bsr_pkg::t_state   r_st, n_st;

    logic          r_ov;
    logic [2:0]    r_dst;
    bsr_pkg::t_out_item r_out;

    logic [3:0] w_np;
    logic [2:0] w_nr;
    logic [CB-1:0] w_req [MR];
    logic [CB-1:0] w_rowa [MR];
    logic [CB-1:0] w_rown [MR];
    logic          w_fits, w_over, w_wait, w_lbad, w_slot;

    assign w_np = (i_cfg.np == 4'd0) ? 4'd1 : (i_cfg.np > 4'(MP)) ? 4'(MP) : i_cfg.np;
    assign w_nr = (i_cfg.nr == 3'd0) ? 3'd1 : (i_cfg.nr > 3'(MR)) ? 3'(MR) : i_cfg.nr;
    assign w_slot = !r_ov || i_pop;
    assign o_empty = !r_ov;
    assign o_res = r_out;

    always_comb begin
        w_req[0] = r_it.req_units_0;
        w_req[1] = r_it.req_units_1;
        w_req[2] = r_it.req_units_2;
        w_req[3] = r_it.req_units_3;
        for (int r = 0; r < MR; r++) begin
            if (r_try && r_p == r_it.proc_index) begin
                w_rowa[r] = r_talloc[r];
                w_rown[r] = r_tneed[r];
            end else begin
                w_rowa[r] = r_alloc[r_p][r];
                w_rown[r] = r_need[r_p][r];
            end
        end
        w_fits = !r_fin[r_p];
        w_over = 1'b0;
        w_wait = 1'b0;
        for (int r = 0; r < MR; r++) begin
            if (3'(r) < w_nr) begin
                if (WB'(w_rown[r]) > r_work[r]) w_fits = 1'b0;
                if (w_req[r] > r_need[r_it.proc_index][r]) w_over = 1'b1;
                if (w_req[r] > r_avail[r]) w_wait = 1'b1;
            end
        end
        if (4'(r_it.proc_index) >= w_np) w_over = 1'b1;
        w_lbad = (3'(r_it.res_index) >= w_nr) ||
                 (r_it.op != 3'(bsr_pkg::OP_LOAD_AVAIL) && 4'(r_it.proc_index) >= w_np) ||
                 (r_it.op == 3'(bsr_pkg::OP_LOAD_MAX) &&
                  r_it.load_value < r_alloc[r_it.proc_index][r_it.res_index]);
    end

    always_comb begin
        n_st = r_st;
        o_take = 1'b0;
        case (r_st)
            bsr_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    case (i_item.op)
                        3'(bsr_pkg::OP_SAFETY):  n_st = bsr_pkg::S_INIT;
                        3'(bsr_pkg::OP_REQUEST): n_st = bsr_pkg::S_RCHK;
                        default:                 n_st = bsr_pkg::S_LOAD;
                    endcase
                end
            end
            bsr_pkg::S_LOAD:   if (w_slot) n_st = bsr_pkg::S_IDLE;
            bsr_pkg::S_RCHK:   n_st = (w_over || w_wait) ? bsr_pkg::S_DONE : bsr_pkg::S_TRY;
            bsr_pkg::S_TRY:    n_st = bsr_pkg::S_INIT;
            bsr_pkg::S_INIT:   n_st = bsr_pkg::S_SCAN;
            bsr_pkg::S_SCAN: begin
                if (4'(r_cnt) == w_np) n_st = r_try ? bsr_pkg::S_COMMIT : bsr_pkg::S_EMIT;
                else if (4'(r_p) + 4'd1 == w_np) n_st = bsr_pkg::S_PASS;
            end
            bsr_pkg::S_PASS:   n_st = r_found ? bsr_pkg::S_SCAN : bsr_pkg::S_DONE;
            bsr_pkg::S_EMIT:   if (w_slot && 4'(r_p) + 4'd1 == w_np) n_st = bsr_pkg::S_IDLE;
            bsr_pkg::S_COMMIT: n_st = bsr_pkg::S_DONE;
            bsr_pkg::S_DONE:   if (w_slot) n_st = bsr_pkg::S_IDLE;
            default:           n_st = bsr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bsr_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_fin <= '0;
            for (int p = 0; p < MP; p++) begin
                for (int r = 0; r < MR; r++) begin
                    r_alloc[p][r] <= '0;
                    r_need[p][r]  <= '0;
                end
            end
            for (int r = 0; r < MR; r++) begin
                r_avail[r] <= '0;
                r_work[r]  <= '0;
            end
        end else begin
            r_st <= n_st;
            if (i_pop && r_ov) r_ov <= 1'b0;
            case (r_st)
                bsr_pkg::S_IDLE: begin
                    r_it  <= i_item;
                    r_try <= 1'b0;
                end
                bsr_pkg::S_LOAD: begin
                    if (w_slot) begin
                        r_ov  <= 1'b1;
                        r_out <= '{status: w_lbad ? 3'(bsr_pkg::ST_LOAD_BAD)
                                                 : 3'(bsr_pkg::ST_LOAD_OK),
                                   seq_process: 3'd0, last: 1'b1};
                        if (!w_lbad) begin
                            case (r_it.op)
                                3'(bsr_pkg::OP_LOAD_ALLOC):
                                    r_alloc[r_it.proc_index][r_it.res_index] <= r_it.load_value;
                                3'(bsr_pkg::OP_LOAD_MAX):
                                    r_need[r_it.proc_index][r_it.res_index] <= r_it.load_value -
                                        r_alloc[r_it.proc_index][r_it.res_index];
                                default: r_avail[r_it.res_index] <= r_it.load_value;
                            endcase
                        end
                    end
                end
                bsr_pkg::S_RCHK: begin
                    r_dst <= w_over ? 3'(bsr_pkg::ST_OVER) : 3'(bsr_pkg::ST_WAIT);
                end
                bsr_pkg::S_TRY: begin
                    r_try <= 1'b1;
                    for (int r = 0; r < MR; r++) begin
                        if (3'(r) < w_nr) begin
                            r_tavail[r] <= r_avail[r] - w_req[r];
                            r_tneed[r]  <= r_need[r_it.proc_index][r] - w_req[r];
                            if ({1'b0, r_alloc[r_it.proc_index][r]} + {1'b0, w_req[r]} >
                                {1'b0, {CB{1'b1}}})
                                r_talloc[r] <= {CB{1'b1}};
                            else
                                r_talloc[r] <= r_alloc[r_it.proc_index][r] + w_req[r];
                        end else begin
                            r_tavail[r] <= r_avail[r];
                            r_tneed[r]  <= r_need[r_it.proc_index][r];
                            r_talloc[r] <= r_alloc[r_it.proc_index][r];
                        end
                    end
                end
                bsr_pkg::S_INIT: begin
                    r_fin   <= '0;
                    r_cnt   <= '0;
                    r_p     <= '0;
                    r_found <= 1'b0;
                    for (int r = 0; r < MR; r++) begin
                        if (3'(r) >= w_nr) r_work[r] <= '0;
                        else if (r_try) r_work[r] <= WB'(r_tavail[r]);
                        else r_work[r] <= WB'(r_avail[r]);
                    end
                end
                bsr_pkg::S_SCAN, bsr_pkg::S_PASS: begin
                    if (4'(r_cnt) != w_np) begin
                        if (w_fits && r_st == bsr_pkg::S_SCAN) begin
                            for (int r = 0; r < MR; r++) begin
                                if (3'(r) < w_nr) begin
                                    if ({1'b0, r_work[r]} + (WB+1)'(w_rowa[r]) >
                                        (WB+1)'({WB{1'b1}}))
                                        r_work[r] <= {WB{1'b1}};
                                    else
                                        r_work[r] <= r_work[r] + WB'(w_rowa[r]);
                                end
                            end
                            r_fin[r_p] <= 1'b1;
                            r_ord[r_cnt[2:0]] <= r_p;
                            r_cnt <= r_cnt + 4'd1;
                        end
                        if (r_st == bsr_pkg::S_PASS) begin
                            r_p <= '0;
                            r_found <= 1'b0;
                        end else begin
                            r_p <= r_p + 3'd1;
                            r_found <= r_found || w_fits;
                        end
                    end else begin
                        r_p <= '0;
                    end
                    r_dst <= r_try ? 3'(bsr_pkg::ST_UNSAFE) : 3'(bsr_pkg::ST_NOT_SAFE);
                end
                bsr_pkg::S_EMIT: begin
                    if (w_slot) begin
                        r_ov  <= 1'b1;
                        r_out <= '{status: 3'(bsr_pkg::ST_SAFE), seq_process: r_ord[r_p],
                                   last: (4'(r_p) + 4'd1 == w_np)};
                        r_p <= r_p + 3'd1;
                    end
                end
                bsr_pkg::S_COMMIT: begin
                    for (int r = 0; r < MR; r++) begin
                        r_alloc[r_it.proc_index][r] <= r_talloc[r];
                        r_need[r_it.proc_index][r]  <= r_tneed[r];
                        r_avail[r] <= r_tavail[r];
                    end
                    r_dst <= 3'(bsr_pkg::ST_GRANTED);
                end
                bsr_pkg::S_DONE: begin
                    if (w_slot) begin
                        r_ov  <= 1'b1;
                        r_out <= '{status: r_dst, seq_process: 3'd0, last: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    `BSR_ASSERT(a_take_idle, i_clk, i_rst_n, (o_take |-> (r_st == bsr_pkg::S_IDLE)), "take outside idle")
    `BSR_ASSERT(a_cnt_range, i_clk, i_rst_n, ((r_st == bsr_pkg::S_SCAN) |-> (r_cnt <= 4'(MP))), "scan count overrun")
    `BSR_ASSERT(a_out_hold, i_clk, i_rst_n, ((r_ov && !i_pop) |=> r_ov), "result dropped")
    `BSR_ASSERT(a_commit, i_clk, i_rst_n, ((r_st == bsr_pkg::S_COMMIT) |-> r_try), "commit without trial")
endmodule
`default_nettype wire

FILE: hw/rtl/bankers_safety_and_request.sv
// ----------------------------------------------------------------------------
// bankers_safety_and_request
// Banker's algorithm: table loads, safety scan and checked resource requests.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         i_push / o_full    i_item  (t_in_item)
// result    out        i_pop / o_empty    o_res   (t_out_item)
// config    in         APB, pready high   pwdata, paddr[2]
// A safety check walks one process row per cycle over up to N passes of N
// rows; if safe, the safety op emits the sequence, one result per process. A
// two-entry queue decouples the input. Reset is synchronous; tables clear at once.
// A stalled result holds the engine.
`default_nettype none
module bankers_safety_and_request (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  bsr_pkg::t_in_item    i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_empty,
    output bsr_pkg::t_out_item   o_res,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    bsr_pkg::t_cfg     r_cfg;
    bsr_pkg::t_in_item w_qitem;
    logic              w_qvalid, w_take;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bsr_pkg::ADDR_RES) ? {29'd0, r_cfg.nr} : {28'd0, r_cfg.np};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.np <= 4'd8;
            r_cfg.nr <= 3'd4;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == bsr_pkg::ADDR_PROCS && paddr[1:0] == 2'd0) r_cfg.np <= pwdata[3:0];
            if (paddr[2] == bsr_pkg::ADDR_RES && paddr[1:0] == 2'd0)   r_cfg.nr <= pwdata[2:0];
        end
    end

    bsr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(i_item),
        .o_full(o_full), .o_valid(w_qvalid), .o_item(w_qitem), .i_take(w_take)
    );

    bsr_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_valid(w_qvalid),
        .i_item(w_qitem), .o_take(w_take), .i_pop(i_pop), .o_empty(o_empty),
        .o_res(o_res)
    );
endmodule
`default_nettype wire
